/* hw/rtl/flsl_pkg.sv */
// Package for the four-lane float32 logarithm block.
// Holds payload structs, fixed-point constants and the reciprocal table.
// No dependencies.
package flsl_pkg;

   localparam int unsigned NUM_LANES = 4;
   localparam int unsigned YW = 31;
   localparam int unsigned DIV_STEPS = 31;

   localparam logic [31:0] LN2_Q31 = 32'h58B90BFC;
   localparam logic signed [31:0] INV_LN2_Q28 = 32'sd387270502;
   localparam logic [31:0] SCALE_RESET = 32'h10000000;

   typedef enum logic [1:0] {
      MODE_LN   = 2'd0,
      MODE_LOG2 = 2'd1,
      MODE_BASE = 2'd2,
      MODE_RSVD = 2'd3
   } mode_type;

   localparam logic [0:0] REG_LOG_MODE   = 1'b0;
   localparam logic [0:0] REG_BASE_SCALE = 1'b1;

   typedef struct packed {
      logic [31:0] lane3_bits;
      logic [31:0] lane2_bits;
      logic [31:0] lane1_bits;
      logic [31:0] lane0_bits;
   } req_type;

   typedef struct packed {
      logic [3:0]         invalid_mask;
      logic signed [31:0] lane3_log;
      logic signed [31:0] lane2_log;
      logic signed [31:0] lane1_log;
      logic signed [31:0] lane0_log;
   } rsp_type;

   // Q0.32 reciprocals of 3,5,...,13, rounded to nearest.
   function automatic logic [31:0] recip_q32(input logic [2:0] k);
      logic [31:0] r;
      unique case (k)
         3'd0: r = 32'd1431655765;
         3'd1: r = 32'd858993459;
         3'd2: r = 32'd613566757;
         3'd3: r = 32'd477218588;
         3'd4: r = 32'd390451572;
         3'd5: r = 32'd330382100;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/flsl_lane.sv */
// One logarithm lane: a pipelined restoring divider for y, then a pipelined
// odd-power series and the exponent term. Uses flsl_pkg.
module flsl_lane (
   input  logic                clock,
   input  logic [31:0]         bits_in,
   output logic signed [39:0]  ln_out,
   output logic                bad_out
);
   import flsl_pkg::*;

   localparam int unsigned DEPTH = DIV_STEPS + 14;
   // Total depth: DIV_STEPS divider stages, the y register, 12 series stages
   // and the exponent stage.

   logic [8:0]  ex_ff [DEPTH+1];
   logic        bad_ff [DEPTH+1];
   // Divider: remainder and quotient per stage. f<<31 / (2^24+f).
   logic [24:0] rem_ff [DIV_STEPS+1];
   logic [30:0] quo_ff [DIV_STEPS+1];
   logic [23:0] f_ff   [DIV_STEPS+1];
   logic [22:0] fsrc_ff [DIV_STEPS+1];

   always_comb begin
      ex_ff[0]   = {1'b0, bits_in[30:23]};
      bad_ff[0]  = bits_in[31] || bits_in[30:23] == 8'h00 || bits_in[30:23] == 8'hFF;
      rem_ff[0]  = 25'd0;
      quo_ff[0]  = 31'd0;
      f_ff[0]    = 24'd0;
      fsrc_ff[0] = bits_in[22:0];
   end

   // Dividend is f * 2^31 = {f, 31 zeros}; bits enter MSB first (54 bits).
   // The quotient is < 2^31, so the top 23 bits of the dividend can be
   // preloaded into the remainder: start with rem = f (bits 53..31).
   genvar s;
   generate
      for (s = 0; s < DIV_STEPS; s++) begin : g_div
         logic [25:0] trial;
         logic [24:0] d;
         logic [24:0] r0;
         always_comb begin
            d  = 25'h1000000 + {2'b0, (s == 0) ? fsrc_ff[s] : f_ff[s][22:0]};
            r0 = (s == 0) ? {2'b0, fsrc_ff[s]} : rem_ff[s];
            trial = {r0, 1'b0} - {1'b0, d};
         end
         always_ff @(posedge clock) begin
            f_ff[s+1]    <= {1'b0, (s == 0) ? fsrc_ff[s] : f_ff[s][22:0]};
            fsrc_ff[s+1] <= fsrc_ff[s];
            if (!trial[25]) begin
               rem_ff[s+1] <= trial[24:0];
               quo_ff[s+1] <= {quo_ff[s][29:0], 1'b1};
            end else begin
               rem_ff[s+1] <= {r0[23:0], 1'b0};
               quo_ff[s+1] <= {quo_ff[s][29:0], 1'b0};
            end
         end
      end
      for (s = 0; s < DEPTH; s++) begin : g_side
         always_ff @(posedge clock) begin
            ex_ff[s+1]  <= ex_ff[s];
            bad_ff[s+1] <= bad_ff[s];
         end
      end
   endgenerate

   // Series: stage 0 squares y; then six rounds of (mult p*y2, mult p*Rk).
   logic [30:0] y_ff, y2_ff;
   logic [30:0] p_ff [7];
   logic [30:0] y2p_ff [7];
   logic [33:0] sum_ff [7];
   logic [30:0] pm_ff [6];
   logic [30:0] y2m_ff [6];
   logic [33:0] summ_ff [6];
   logic [61:0] sq;
   assign sq = quo_ff[DIV_STEPS] * quo_ff[DIV_STEPS];

   always_ff @(posedge clock) begin
      y_ff  <= quo_ff[DIV_STEPS];
      y2_ff <= sq[61:31];
   end
   always_comb begin
      p_ff[0]   = y_ff;
      y2p_ff[0] = y2_ff;
      sum_ff[0] = {3'b0, y_ff};
   end

   generate
      for (s = 0; s < 6; s++) begin : g_ser
         logic [61:0] pp;
         logic [62:0] rk;
         assign pp = p_ff[s] * y2p_ff[s];
         assign rk = pm_ff[s] * recip_q32(3'(s));
         always_ff @(posedge clock) begin
            pm_ff[s]   <= pp[61:31];
            y2m_ff[s]  <= y2p_ff[s];
            summ_ff[s] <= sum_ff[s];
            p_ff[s+1]   <= pm_ff[s];
            y2p_ff[s+1] <= y2m_ff[s];
            sum_ff[s+1] <= summ_ff[s] + {3'b0, rk[62:32]};
         end
      end
   endgenerate

   logic signed [39:0] eterm;
   logic signed [8:0]  e_s;
   logic signed [39:0] ln_ff;
   assign e_s   = $signed(ex_ff[DEPTH-1] - 9'd127);
   assign eterm = 40'(e_s) * $signed({8'b0, LN2_Q31});
   always_ff @(posedge clock) begin
      ln_ff <= eterm + $signed({5'b0, sum_ff[6], 1'b0});
   end
   assign ln_out  = ln_ff;
   assign bad_out = bad_ff[DEPTH];
endmodule

/* hw/rtl/flsl_merge.sv */
// Merging stage: mode scaling, rounding and saturation of all lanes.
// Uses flsl_pkg.
module flsl_merge #(
   parameter int LANES = 4
) (
   input  logic                     clock,
   input  logic [LANES-1:0][39:0]   ln_in,
   input  logic [LANES-1:0]         bad_in,
   input  logic [1:0]               mode_in,
   input  logic signed [31:0]       scale_in,
   output logic [LANES-1:0][31:0]   log_out,
   output logic [LANES-1:0]         bad_out
);
   import flsl_pkg::*;

   logic [LANES-1:0][33:0] l24_ff;
   logic [LANES-1:0][31:0] m0_ff;
   logic [LANES-1:0]       bad1_ff, bad2_ff;
   logic                   scl1_ff;
   logic signed [31:0]     sc_ff;
   logic [LANES-1:0][65:0] prod_ff;
   logic [LANES-1:0][31:0] m0b_ff;
   logic                   scl2_ff;

   function automatic logic [31:0] sat(input logic signed [66:0] v);
      if (v > 67'sd2147483647) return 32'h7FFFFFFF;
      if (v < -67'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   always_ff @(posedge clock) begin
      scl1_ff <= mode_in == MODE_LOG2 || mode_in == MODE_BASE;
      sc_ff   <= (mode_in == MODE_LOG2) ? INV_LN2_Q28 : scale_in;
      bad1_ff <= bad_in;
      for (int i = 0; i < LANES; i++) begin
         logic signed [40:0] a;
         logic signed [40:0] b;
         a = $signed({ln_in[i][39], ln_in[i]}) + 41'sd64;
         b = $signed({ln_in[i][39], ln_in[i]}) + 41'sd256;
         l24_ff[i] <= 34'(a >>> 7);
         m0_ff[i]  <= sat(67'(b >>> 9));
      end
   end

   always_ff @(posedge clock) begin
      scl2_ff <= scl1_ff;
      bad2_ff <= bad1_ff;
      for (int i = 0; i < LANES; i++) begin
         prod_ff[i] <= 66'($signed(l24_ff[i]) * sc_ff);
         m0b_ff[i]  <= m0_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      bad_out <= bad2_ff;
      for (int i = 0; i < LANES; i++) begin
         logic signed [66:0] t;
         t = $signed({prod_ff[i][65], prod_ff[i]}) + 67'sd536870912;
         if (bad2_ff[i]) log_out[i] <= 32'd0;
         else if (scl2_ff) log_out[i] <= sat(t >>> 30);
         else log_out[i] <= m0b_ff[i];
      end
   end
endmodule

/* hw/rtl/float_log_series_lanes_core.sv */
// Top level of the float32 logarithm block: lanes, merging stage, CSRs.
// Depends on flsl_pkg, flsl_lane and flsl_merge.
//
// Usage: drive req_data and raise start while busy is low; the item is
// taken at that edge. busy is always low here, so one item is accepted
// every cycle. Each item carries four IEEE single-precision values.
// The result appears on rsp_data with rsp_valid high for one cycle, after
// 31 divider stages for y, 13 series stages (square plus six multiply pairs),
// one exponent stage and three scaling stages, the last of which is the
// output register. Throughput is one item per cycle.
// The receiver cannot stall; results must be taken when shown.
// The CSR channel (csr_valid/csr_ready, csr_index, csr_wdata) writes
// log_mode (index 0) and base_scale (index 1); other indices are ignored.
// csr_ready is always high. Write only while no items are in flight.
// Reset (synchronous) clears the pipeline valid bits and restores the
// registers to natural-log mode with a unit base scale.
module float_log_series_lanes_core #(
   parameter int LANES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  flsl_pkg::req_type req_data,
   output logic              rsp_valid,
   output flsl_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import flsl_pkg::*;

   localparam int unsigned LAT = DIV_STEPS + 13 + 1 + 3;

   logic [1:0]         mode_ff;
   logic signed [31:0] scale_ff;
   logic [LAT-1:0]     vld_ff;
   logic [LANES-1:0][31:0] bits;
   logic [LANES-1:0][39:0] ln;
   logic [LANES-1:0]       bad;
   logic [LANES-1:0][31:0] lg;
   logic [LANES-1:0]       bado;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_LN;
         scale_ff <= SCALE_RESET;
         vld_ff   <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start && !busy};
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_LOG_MODE:   mode_ff  <= csr_wdata[1:0];
               REG_BASE_SCALE: scale_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Lanes beyond the four input fields see a zero pattern (invalid).
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         unique case (i)
            0: bits[i] = req_data.lane0_bits;
            1: bits[i] = req_data.lane1_bits;
            2: bits[i] = req_data.lane2_bits;
            3: bits[i] = req_data.lane3_bits;
            default: bits[i] = 32'd0;
         endcase
      end
   end

   genvar g;
   generate
      for (g = 0; g < LANES; g++) begin : g_lane
         flsl_lane u_lane (
            .clock  (clock),
            .bits_in(bits[g]),
            .ln_out (ln[g]),
            .bad_out(bad[g])
         );
      end
   endgenerate

   flsl_merge #(.LANES(LANES)) u_merge (
      .clock   (clock),
      .ln_in   (ln),
      .bad_in  (bad),
      .mode_in (mode_ff),
      .scale_in(scale_ff),
      .log_out (lg),
      .bad_out (bado)
   );

   always_comb begin
      rsp_data = '0;
      rsp_data.lane0_log = lg[0];
      if (LANES > 1) rsp_data.lane1_log = lg[1 % LANES];
      if (LANES > 2) rsp_data.lane2_log = lg[2 % LANES];
      if (LANES > 3) rsp_data.lane3_log = lg[3 % LANES];
      for (int i = 0; i < LANES && i < 4; i++) rsp_data.invalid_mask[i] = bado[i];
   end
   assign rsp_valid = vld_ff[LAT-1];

   // An invalid lane 0 always reports zero.
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.invalid_mask[0] |-> rsp_data.lane0_log == 32'd0)
      else $error("invalid lane 0 not zero");
   // A result is shown only if the valid stage before the output held an item.
   a_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vld_ff[LAT-2]))
      else $error("result without item");
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == REG_LOG_MODE |=> mode_ff == $past(csr_wdata[1:0]))
      else $error("mode write lost");
endmodule

/* tb/sv/flsl_checker.sv */
// Checker for the four-lane float32 logarithm block: predicts and compares results.
// Depends on flsl_pkg; watches the request, result and CSR channels of the core.
`timescale 1ns / 1ps

module flsl_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  flsl_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  flsl_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output int                fail_count,
   output int                pending
);
   import flsl_pkg::*;

   localparam longint unsigned RECIP [6] = '{1431655765, 858993459, 613566757,
                                              477218588, 390451572, 330382100};

   mode_type          cur_mode;
   logic signed [31:0] cur_scale;
   rsp_type           expected_logs[$];

   // One lane: natural log in Q.31 from the odd series, then the mode scaling.
   function automatic void lane_log(input logic [31:0] bits, input mode_type mode,
                                    input logic signed [31:0] scale,
                                    output logic [31:0] value, output logic bad);
      longint unsigned f, y, y2, p, sum;
      longint          e, ln, l24, r, s;
      f = bits[22:0];
      bad = bits[31] || bits[30:23] == 8'h00 || bits[30:23] == 8'hFF;
      value = '0;
      if (!bad) begin
         e = longint'(bits[30:23]) - 127;
         y = (f << 31) / ((64'd1 << 24) + f);
         y2 = (y * y) >> 31;
         p = y;
         sum = y;
         for (int k = 0; k < 6; k++) begin
            p = (p * y2) >> 31;
            sum += (p * RECIP[k]) >> 32;
         end
         ln = e * longint'(LN2_Q31) + 2 * longint'(sum);
         if (mode == MODE_LOG2 || mode == MODE_BASE) begin
            s = (mode == MODE_LOG2) ? longint'(INV_LN2_Q28) : longint'(scale);
            l24 = (ln + 64) >>> 7;
            r = (l24 * s + (64'sd1 <<< 29)) >>> 30;
         end else begin
            r = (ln + 256) >>> 9;
         end
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         value = r[31:0];
      end
   endfunction

   function automatic rsp_type predict_logs(input req_type d, input mode_type mode,
                                            input logic signed [31:0] scale);
      rsp_type   res;
      logic [31:0] v;
      logic        b;
      res = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_log(d[32*i +: 32], mode, scale, v, b);
         res[32*i +: 32] = v;
         res.invalid_mask[i] = b;
      end
      return res;
   endfunction

   assign pending = expected_logs.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cur_mode <= MODE_LN;
         cur_scale <= SCALE_RESET;
         expected_logs.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_LOG_MODE) cur_mode <= mode_type'(csr_wdata[1:0]);
            else if (csr_index == REG_BASE_SCALE) cur_scale <= csr_wdata;
         end
         if (start && !busy)
            expected_logs.push_back(predict_logs(req_data, cur_mode, cur_scale));
         if (rsp_valid) begin
            if (expected_logs.size() == 0) begin
               $error("result with no item outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_logs.pop_front();
               if (want != rsp_data) fail_count <= fail_count + 1;
               for (int i = 0; i < NUM_LANES; i++)
                  if (want[32*i +: 32] != rsp_data[32*i +: 32])
                     $error("lane%0d_log expected %0d actual %0d", i,
                            $signed(want[32*i +: 32]), $signed(rsp_data[32*i +: 32]));
               if (want.invalid_mask != rsp_data.invalid_mask)
                  $error("invalid_mask expected %b actual %b", want.invalid_mask,
                         rsp_data.invalid_mask);
            end
         end
      end
   end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for float_log_series_lanes_core: clock, reset, stimulus and verdict.
// Depends on flsl_pkg, the core RTL and flsl_checker.
`timescale 1ns / 1ps

module tb_top;
   import flsl_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = REG_LOG_MODE;
   logic [31:0] csr_wdata = '0;
   int          fail_count;
   int          pending;
   bit          no_gaps;

   always #5 clock = ~clock;

   float_log_series_lanes_core i_dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   flsl_checker i_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata, .fail_count, .pending
   );

   // Present one item at the falling edge and hold it until the core takes it.
   task automatic send_item(input req_type d);
      @(negedge clock);
      start <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (busy);
   endtask

   // Drop start for a random gap: mostly none or short, now and then long.
   task automatic random_gap();
      int n;
      int pick;
      pick = $urandom_range(99);
      if (no_gaps || pick < 55) n = 0;
      else if (pick < 92) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 40);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Registers change only when every outstanding item has come back, since
   // each item always produces exactly one result.
   task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A random lane value: mostly normal positive numbers, which take the full
   // series path, with a share of negatives, subnormals and NaNs.
   function automatic logic [31:0] random_lane();
      logic [31:0] v;
      int          pick;
      v = $urandom();
      pick = $urandom_range(99);
      if (pick < 80) begin
         v[31] = 1'b0;
         if (v[30:23] == 8'h00 || v[30:23] == 8'hFF) v[30:23] = 8'($urandom_range(1, 254));
      end else if (pick < 84) v[30:23] = 8'h00;
      else if (pick < 88) v[30:23] = 8'hFF;
      else if (pick < 92) v[30:0] = 31'($urandom_range(1, 254) << 23 | v[22:0] & 32'h3);
      return v;
   endfunction

   task automatic random_items(input int count);
      req_type d;
      no_gaps = ($urandom_range(3) == 0);
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < NUM_LANES; i++) d[32*i +: 32] = random_lane();
         send_item(d);
         random_gap();
      end
   endtask

   // Directed values: one and two, extremes of the normal range and mantissa,
   // and every kind of invalid input (zero, minus zero, subnormal, infinity,
   // NaN, negative number).
   logic [31:0] directed_vals [16] = '{
      32'h3F800000, 32'h40000000, 32'h00800000, 32'h7F7FFFFF,
      32'h3FFFFFFF, 32'h3F800001, 32'h00FFFFFF, 32'h7F000000,
      32'h00000000, 32'h80000000, 32'h00000001, 32'h007FFFFF,
      32'h7F800000, 32'h7FC00000, 32'hBF800000, 32'hFF7FFFFF
   };

   task automatic directed_items();
      req_type d;
      for (int n = 0; n < 16; n += 4) begin
         for (int i = 0; i < NUM_LANES; i++) d[32*i +: 32] = directed_vals[n + i];
         send_item(d);
      end
      // Rotate the same values through other lanes so each lane sees half of the values.
      for (int n = 0; n < 16; n += 4) begin
         for (int i = 0; i < NUM_LANES; i++)
            d[32*i +: 32] = directed_vals[(n + i + 5) % 16];
         send_item(d);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings first: natural log with unit scale.
      directed_items();
      random_items(140);

      write_reg(REG_LOG_MODE, 32'(MODE_LOG2));
      directed_items();
      random_items(140);

      write_reg(REG_LOG_MODE, 32'(MODE_BASE));
      directed_items();
      random_items(120);

      write_reg(REG_BASE_SCALE, 32'h7FFFFFFF);
      directed_items();
      random_items(110);

      write_reg(REG_BASE_SCALE, 32'h80000000);
      directed_items();
      random_items(110);

      write_reg(REG_BASE_SCALE, 32'h00000000);
      random_items(60);

      write_reg(REG_BASE_SCALE, $urandom());
      random_items(110);

      // The unused mode value acts as natural log; upper data bits are don't-care.
      write_reg(REG_LOG_MODE, {30'h3FFFFFFF, MODE_RSVD});
      directed_items();
      random_items(110);

      write_reg(REG_LOG_MODE, 32'(MODE_LN));
      random_items(80);

      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
